// File: src/rlpx_pkg.sv
// Shared constants, types and state encoding for the run-length row pixel expander.
`default_nettype none

package rlpx_pkg;

   localparam int TABLE_ROWS_DEFAULT = 128;
   localparam int ROW_SLOTS_DEFAULT  = 32;

   localparam logic [1:0] OP_WRITE   = 2'd0;
   localparam logic [1:0] OP_RESTART = 2'd1;
   localparam logic [1:0] OP_FETCH   = 2'd2;

   localparam logic       CSR_ROWS_OUT     = 1'b0;
   localparam logic       CSR_ENTRIES_USED = 1'b1;

   localparam logic [7:0] ROWS_OUT_RESET     = 8'd220;
   localparam logic [5:0] ENTRIES_USED_RESET = 6'd25;

   localparam logic [15:0] COLOR_ON  = 16'h07FF;
   localparam logic [15:0] COLOR_OFF = 16'h0000;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_LOAD0,
      ST_NEXT
   } state_type;

   typedef struct packed {
      logic req_ready;
      logic do_write;
      logic do_restart;
      logic rd_first;
      logic rd_next;
      logic load_first;
      logic load_next;
      logic emit_pix;
      logic emit_end;
      logic row_adv;
   } cmd_type;

   typedef struct packed {
      logic frame_done;
      logic row_loaded;
      logic run_nz;
      logic next_ok;
      logic rdata_nz;
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

// File: src/rlpx_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rlpx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: src/rlpx_ctrl.sv
// Controller state machine that sequences table writes, restarts and pixel fetches.
`default_nettype none

module rlpx_ctrl
   import rlpx_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic [1:0] req_opcode,
   input  wire stat_type   stat,
   output cmd_type         cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_opcode == OP_FETCH) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (stat.frame_done) begin
               if (stat.out_free) begin
                  state_in = ST_IDLE;
               end
            end else if (!stat.row_loaded) begin
               state_in = ST_LOAD0;
            end else if (stat.run_nz) begin
               if (stat.out_free) begin
                  state_in = ST_IDLE;
               end
            end else if (stat.next_ok) begin
               state_in = ST_NEXT;
            end
         end
         ST_LOAD0: state_in = ST_EVAL;
         ST_NEXT:  state_in = ST_EVAL;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.req_ready  = 1'b1;
            cmd.do_write   = req_valid && req_opcode == OP_WRITE;
            cmd.do_restart = req_valid && req_opcode == OP_RESTART;
         end
         ST_EVAL: begin
            if (stat.frame_done) begin
               cmd.emit_end = stat.out_free;
            end else if (!stat.row_loaded) begin
               cmd.rd_first = 1'b1;
            end else if (stat.run_nz) begin
               cmd.emit_pix = stat.out_free;
            end else if (stat.next_ok) begin
               cmd.rd_next = 1'b1;
            end else begin
               cmd.row_adv = 1'b1;
            end
         end
         ST_LOAD0: cmd.load_first = 1'b1;
         ST_NEXT: begin
            cmd.load_next = stat.rdata_nz;
            cmd.row_adv   = !stat.rdata_nz;
         end
         default: cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

// File: src/rlpx_dp.sv
// Datapath holding the expansion state, configuration, edge table and result register.
`default_nettype none

module rlpx_dp
   import rlpx_pkg::*;
#(
   parameter int TABLE_ROWS = TABLE_ROWS_DEFAULT,
   parameter int ROW_SLOTS  = ROW_SLOTS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output stat_type         stat,
   input  wire logic [6:0]  req_table_row,
   input  wire logic [4:0]  req_table_slot,
   input  wire logic [7:0]  req_table_value,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_wdata,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_pixel_color,
   output logic [7:0]       rsp_pixel_row,
   output logic             rsp_pixel_valid
);

   localparam int DEPTH  = TABLE_ROWS * ROW_SLOTS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int TROW_W = $clog2(TABLE_ROWS);

   logic [7:0]        rows_out_ff;
   logic [5:0]        entries_ff;
   logic [7:0]        row_ff;
   logic [TROW_W-1:0] trow_ff;
   logic [5:0]        slot_ff;
   logic [7:0]        run_ff;
   logic [7:0]        prev_ff;
   logic              loaded_ff;
   logic              rsp_valid_ff;
   logic [15:0]       color_ff;
   logic [7:0]        prow_ff;
   logic              pvalid_ff;

   logic [6:0]        next_slot;
   logic [6:0]        limit;
   logic [7:0]        rd_data;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] row_base;

   assign next_slot = {1'b0, slot_ff} + 7'd1;
   assign limit     = ({1'b0, entries_ff} > 7'(ROW_SLOTS)) ? 7'(ROW_SLOTS)
                                                           : {1'b0, entries_ff};

   assign wr_en   = cmd.do_write && ({1'b0, req_table_row} < 8'(TABLE_ROWS))
                    && ({2'b00, req_table_slot} < 7'(ROW_SLOTS));
   assign wr_addr = ADDR_W'(req_table_row) * ADDR_W'(ROW_SLOTS) + ADDR_W'(req_table_slot);
   assign row_base = ADDR_W'(trow_ff) * ADDR_W'(ROW_SLOTS);
   assign rd_addr  = cmd.rd_first ? row_base : row_base + ADDR_W'(next_slot);

   rlpx_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_table_value),
      .rd_en   (cmd.rd_first | cmd.rd_next),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign stat.frame_done = row_ff >= rows_out_ff;
   assign stat.row_loaded = loaded_ff;
   assign stat.run_nz     = run_ff != 8'd0;
   assign stat.next_ok    = next_slot < limit;
   assign stat.rdata_nz   = rd_data != 8'd0;
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_out_ff <= ROWS_OUT_RESET;
         entries_ff  <= ENTRIES_USED_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROWS_OUT:     rows_out_ff <= csr_wdata;
            CSR_ENTRIES_USED: entries_ff  <= csr_wdata[5:0];
            default:          rows_out_ff <= rows_out_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.do_restart) begin
         row_ff    <= 8'd0;
         trow_ff   <= '0;
         slot_ff   <= 6'd0;
         run_ff    <= 8'd0;
         prev_ff   <= 8'd0;
         loaded_ff <= 1'b0;
      end else begin
         if (cmd.load_first) begin
            run_ff    <= rd_data;
            prev_ff   <= rd_data;
            slot_ff   <= 6'd0;
            loaded_ff <= 1'b1;
         end
         if (cmd.load_next) begin
            run_ff  <= rd_data - prev_ff;
            prev_ff <= rd_data;
            slot_ff <= next_slot[5:0];
         end
         if (cmd.emit_pix) begin
            run_ff <= run_ff - 8'd1;
         end
         if (cmd.row_adv) begin
            row_ff    <= row_ff + 8'd1;
            loaded_ff <= 1'b0;
            if (row_ff[0]) begin
               trow_ff <= (trow_ff == TROW_W'(TABLE_ROWS - 1)) ? '0
                                                               : trow_ff + TROW_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_pix || cmd.emit_end) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_pix) begin
         color_ff  <= slot_ff[0] ? COLOR_ON : COLOR_OFF;
         prow_ff   <= row_ff;
         pvalid_ff <= 1'b1;
      end else if (cmd.emit_end) begin
         color_ff  <= COLOR_OFF;
         prow_ff   <= 8'd0;
         pvalid_ff <= 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_color = color_ff;
   assign rsp_pixel_row   = prow_ff;
   assign rsp_pixel_valid = pvalid_ff;

endmodule

`default_nettype wire

// File: src/run_length_row_pixel_expand.sv
// Top level of the run-length row pixel expander.
`default_nettype none

// Expands a table of edge positions into RGB565 pixels, one pixel per fetch
// transfer; table writes and restarts give no result. Writes land in the
// table in the cycle that they are accepted. A fetch while a run is in
// progress is served from EVAL; each table read it needs (the first slot of
// a row, and each step to a following slot) passes through LOAD0 or NEXT
// because the table is a single-read-port RAM with registered output. A row
// that ends at a zero entry advances in the NEXT state of that read, while
// a row that ends at the slot limit advances from EVAL with no further read.
// Every fetch returns one result transfer, with pixel_valid low once the
// frame is finished. The result sits in an output register, so the next
// request is taken while it waits; a fetch that reaches its result while the
// previous one is still waiting holds until that one leaves.
module run_length_row_pixel_expand
   import rlpx_pkg::*;
#(
   parameter int TABLE_ROWS = TABLE_ROWS_DEFAULT,
   parameter int ROW_SLOTS  = ROW_SLOTS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [6:0]  req_table_row,
   input  wire logic [4:0]  req_table_slot,
   input  wire logic [7:0]  req_table_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_pixel_color,
   output logic [7:0]       rsp_pixel_row,
   output logic             rsp_pixel_valid,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   rlpx_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .stat       (stat),
      .cmd        (cmd)
   );

   rlpx_dp #(
      .TABLE_ROWS (TABLE_ROWS),
      .ROW_SLOTS  (ROW_SLOTS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_table_row   (req_table_row),
      .req_table_slot  (req_table_slot),
      .req_table_value (req_table_value),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_pixel_row   (rsp_pixel_row),
      .rsp_pixel_valid (rsp_pixel_valid)
   );

   assign req_ready = cmd.req_ready;

endmodule

`default_nettype wire
